// ===== src/vid_pkg.sv =====
// Shared types, constants and helper functions for the vertex index dedup core.
package vid_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int INDEX_BITS  = 16;
	localparam int FIELD_W     = 16;
	localparam int IDX_W       = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
	localparam int NUM_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int VALUE_W     = 18;
	localparam int SIZE_W      = 3;
	localparam int WORD_W      = 2;
	localparam int ADDR_W      = IDX_W + SIZE_W;
	localparam logic [SIZE_W-1:0] MAX_WORDS = SIZE_W'(4);

	localparam logic [SIZE_W-1:0] POSITION_SIZE_RST = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] NORMAL_SIZE_RST   = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] TEXCOORD_SIZE_RST = SIZE_W'(2);

	typedef enum logic [1:0] {
		ATTR_POSITION,
		ATTR_NORMAL,
		ATTR_TEXCOORD,
		ATTR_VERTEX
	} kind_t;

	typedef enum logic [1:0] {
		REG_POSITION_SIZE,
		REG_NORMAL_SIZE,
		REG_TEXCOORD_SIZE
	} reg_index_t;

	typedef struct packed {
		logic               mode;
		logic [FIELD_W-1:0] position_index;
		logic [FIELD_W-1:0] normal_index;
		logic [FIELD_W-1:0] texcoord_index;
	} corner_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               is_new;
		logic               table_full;
		logic               last;
	} result_t;

	typedef logic [2:0][IDX_W-1:0]  key_t;
	typedef logic [2:0][SIZE_W-1:0] sizes_t;

	// Item as it travels down the cell row
	typedef struct packed {
		logic             vld;
		logic             clr;
		key_t             key;
		logic             hit;
		logic             stored;
		logic [NUM_W-1:0] num;
	} item_t;

	// Word count of one attribute, limited to four; zero for the vertex slot.
	function automatic logic [SIZE_W-1:0] eff_size(sizes_t sizes, kind_t attr);
		logic [SIZE_W-1:0] s;
		s = '0;
		case (attr)
			ATTR_POSITION: s = sizes[0];
			ATTR_NORMAL:   s = sizes[1];
			ATTR_TEXCOORD: s = sizes[2];
			default:       s = '0;
		endcase
		return (s > MAX_WORDS) ? MAX_WORDS : s;
	endfunction

	// First attribute at or after start with a nonzero size, else the vertex slot.
	function automatic kind_t next_attr(sizes_t sizes, logic [1:0] start);
		kind_t r;
		logic  found;
		r = ATTR_VERTEX;
		found = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!found && (2'(i) >= start) && (eff_size(sizes, kind_t'(2'(i))) != '0)) begin
				r = kind_t'(2'(i));
				found = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/vid_cell.sv =====
// One table cell: holds one stored triple and matches or stores the passing item.
module vid_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [vid_pkg::NUM_W-1:0] idx,
	input  vid_pkg::item_t            item_in,
	output vid_pkg::item_t            item_out
);

	logic            occ_q;
	vid_pkg::key_t   entry_q;
	vid_pkg::item_t  item_q;
	vid_pkg::item_t  item_nxt;
	logic            do_store;

	always_comb begin
		item_nxt = item_in;
		do_store = 1'b0;
		if (item_in.vld && !item_in.clr && !item_in.hit && !item_in.stored) begin
			if (occ_q && (entry_q == item_in.key)) begin
				item_nxt.hit = 1'b1;
				item_nxt.num = idx;
			end else if (!occ_q) begin
				do_store = 1'b1;
				item_nxt.stored = 1'b1;
				item_nxt.num = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_nxt;
			if (item_in.vld && item_in.clr) begin
				occ_q <= 1'b0;
			end else if (do_store) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_store) begin
			entry_q <= item_in.key;
		end
	end

	assign item_out = item_q;

endmodule

// ===== src/vid_emit.sv =====
// Result sequencer: turns a finished item into address beats and a vertex number beat.
module vid_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  vid_pkg::sizes_t  sizes,
	input  vid_pkg::item_t   tail,
	output logic             take,
	output logic             result_valid,
	input  logic             result_stall,
	output vid_pkg::result_t result
);

	logic                       busy_q;
	vid_pkg::key_t              key_q;
	logic [vid_pkg::NUM_W-1:0]  num_q;
	logic                       new_q;
	logic                       full_q;
	vid_pkg::kind_t             attr_q;
	logic [vid_pkg::WORD_W-1:0] word_q;

	logic [vid_pkg::IDX_W-1:0]  sel_key;
	logic [vid_pkg::SIZE_W-1:0] sel_sz;
	logic [vid_pkg::ADDR_W-1:0] addr;
	logic                       beat;
	logic                       load;

	assign beat = busy_q && !result_stall;
	assign take = !busy_q || (beat && (attr_q == vid_pkg::ATTR_VERTEX));
	assign load = take && tail.vld && !tail.clr;

	always_comb begin
		sel_key = '0;
		case (attr_q)
			vid_pkg::ATTR_POSITION: sel_key = key_q[0];
			vid_pkg::ATTR_NORMAL:   sel_key = key_q[1];
			vid_pkg::ATTR_TEXCOORD: sel_key = key_q[2];
			default:                sel_key = '0;
		endcase
		sel_sz = vid_pkg::eff_size(sizes, attr_q);
		addr = vid_pkg::ADDR_W'(vid_pkg::ADDR_W'(sel_key) * vid_pkg::ADDR_W'(sel_sz))
			+ vid_pkg::ADDR_W'(word_q);
	end

	always_comb begin
		result_valid      = busy_q;
		result.kind       = attr_q;
		result.is_new     = new_q;
		result.table_full = full_q;
		result.last       = (attr_q == vid_pkg::ATTR_VERTEX);
		if (attr_q == vid_pkg::ATTR_VERTEX) begin
			result.value = full_q ? '0 : vid_pkg::VALUE_W'(num_q);
		end else begin
			result.value = vid_pkg::VALUE_W'(addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			attr_q <= vid_pkg::ATTR_VERTEX;
			word_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			attr_q <= tail.stored ? vid_pkg::next_attr(sizes, 2'd0) : vid_pkg::ATTR_VERTEX;
			word_q <= '0;
		end else if (beat) begin
			if (attr_q == vid_pkg::ATTR_VERTEX) begin
				busy_q <= 1'b0;
			end else if ((vid_pkg::SIZE_W'(word_q) + vid_pkg::SIZE_W'(1)) < sel_sz) begin
				word_q <= word_q + vid_pkg::WORD_W'(1);
			end else begin
				attr_q <= vid_pkg::next_attr(sizes, 2'(attr_q) + 2'd1);
				word_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q  <= tail.key;
			num_q  <= tail.num;
			new_q  <= !tail.hit;
			full_q <= !tail.hit && !tail.stored;
		end
	end

endmodule

// ===== src/vertex_index_dedup_core.sv =====
// Top level of the vertex index dedup core: cell row, size registers and result sequencer.
//
// Each corner beat walks a row of TABLE_DEPTH cells, one cell per cycle while the row
// advances; cell k holds vertex k. A repeated triple stops matching at its cell, a new
// one is written into the first empty cell, and a clear beat empties every cell it
// passes, so beats never see a table state out of order. The row takes one corner beat
// per cycle while the sequencer keeps up; the sequencer gives one result beat per cycle
// unless stalled. A repeated or rejected corner gives one result beat and a new vertex
// gives position_size + normal_size + texcoord_size address beats and a vertex number
// beat (each size counted as at most four). Clear beats give no result. Size registers
// are read by the sequencer and should be written only while no corner is in flight.
module vertex_index_dedup_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        corner_valid,
	output logic                        corner_stall,
	input  vid_pkg::corner_t            corner,
	output logic                        result_valid,
	input  logic                        result_stall,
	output vid_pkg::result_t            result,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [vid_pkg::SIZE_W-1:0]  wr_data
);

	vid_pkg::sizes_t sizes_q;
	vid_pkg::item_t  chain [vid_pkg::TABLE_DEPTH+1];
	logic            adv;
	logic            take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q[0] <= vid_pkg::POSITION_SIZE_RST;
			sizes_q[1] <= vid_pkg::NORMAL_SIZE_RST;
			sizes_q[2] <= vid_pkg::TEXCOORD_SIZE_RST;
		end else if (wr_en) begin
			case (wr_index)
				vid_pkg::REG_POSITION_SIZE: sizes_q[0] <= wr_data;
				vid_pkg::REG_NORMAL_SIZE:   sizes_q[1] <= wr_data;
				vid_pkg::REG_TEXCOORD_SIZE: sizes_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		chain[0].vld    = corner_valid;
		chain[0].clr    = corner.mode;
		chain[0].key[0] = corner.position_index[vid_pkg::IDX_W-1:0];
		chain[0].key[1] = corner.normal_index[vid_pkg::IDX_W-1:0];
		chain[0].key[2] = corner.texcoord_index[vid_pkg::IDX_W-1:0];
		chain[0].hit    = 1'b0;
		chain[0].stored = 1'b0;
		chain[0].num    = '0;
	end

	// row moves unless a finished corner waits on a busy sequencer
	assign adv = !chain[vid_pkg::TABLE_DEPTH].vld || chain[vid_pkg::TABLE_DEPTH].clr || take;
	assign corner_stall = !adv;

	for (genvar g = 0; g < vid_pkg::TABLE_DEPTH; g++) begin : g_cell
		vid_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (vid_pkg::NUM_W'(g)),
			.item_in  (chain[g]),
			.item_out (chain[g+1])
		);
	end

	vid_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.sizes        (sizes_q),
		.tail         (chain[vid_pkg::TABLE_DEPTH]),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== src/vid_chk.sv =====
// Port-level checks for the vertex index dedup core, bound to the top level.
module vid_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       corner_valid,
	input logic                       corner_stall,
	input vid_pkg::corner_t           corner,
	input logic                       result_valid,
	input logic                       result_stall,
	input vid_pkg::result_t           result
);

	// last beat of a corner is always the vertex number
	a_last_is_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.kind == vid_pkg::ATTR_VERTEX)))
		else $error("last flag and kind disagree");

	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.table_full) |->
			(result.is_new && result.last && (result.value == '0)))
		else $error("table full beat malformed");

	a_reuse_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.is_new) |->
			((result.kind == vid_pkg::ATTR_VERTEX) && !result.table_full))
		else $error("reused vertex gave address beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result beat changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(corner_valid && corner_stall) |=> (corner_valid && $stable(corner)))
		else $error("stalled corner beat changed");

endmodule

bind vertex_index_dedup_core vid_chk u_vid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.corner_valid (corner_valid),
	.corner_stall (corner_stall),
	.corner       (corner),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== verif/testbench.sv =====
// Self-checking bench for vertex_index_dedup_core: directed corners, size sweeps, table fill.
module testbench;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       corner_valid;
	logic                       corner_stall;
	vid_pkg::corner_t           corner;
	logic                       result_valid;
	logic                       result_stall;
	vid_pkg::result_t           result;
	logic                       wr_en;
	vid_pkg::reg_index_t        wr_index;
	logic [vid_pkg::SIZE_W-1:0] wr_data;

	vertex_index_dedup_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.corner_valid (corner_valid),
		.corner_stall (corner_stall),
		.corner       (corner),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// welding table as the block should hold it
	logic [vid_pkg::SIZE_W-1:0] size_reg [3];
	vid_pkg::key_t              welded [vid_pkg::TABLE_DEPTH];
	int                         vertex_total;
	vid_pkg::result_t           vertex_results_due [$];
	vid_pkg::corner_t           recent [$];
	bit                         calm;
	int                         mismatch_count;
	int                         n_corner, n_new, n_hit, n_full, n_clear, n_beats, n_settings;
	vid_pkg::result_t           want;

	typedef struct {
		logic        mode;
		logic [15:0] p;
		logic [15:0] n;
		logic [15:0] t;
		bit          typed;
		int          num;
		bit          fresh;
	} probe_t;

	probe_t probes [17] = '{
		'{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 1'b1},
		'{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 1'b0},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b0},
		'{1'b0, 16'h0000, 16'h0000, 16'h0001, 1'b1, 2, 1'b1},
		'{1'b0, 16'h0000, 16'h0001, 16'h0000, 1'b1, 3, 1'b1},
		'{1'b0, 16'h0001, 16'h0000, 16'h0000, 1'b1, 4, 1'b1},
		'{1'b0, 16'h0000, 16'h0000, 16'h0001, 1'b1, 2, 1'b0},
		'{1'b0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 0, 1'b0},
		'{1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 0, 1'b0},
		'{1'b0, 16'h8000, 16'h0001, 16'h7FFF, 1'b0, 0, 1'b0},
		'{1'b0, 16'h0001, 16'h0000, 16'h0000, 1'b1, 4, 1'b0},
		'{1'b1, 16'h1234, 16'hFFFF, 16'h0000, 1'b0, 0, 1'b0},
		'{1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0, 1'b0},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b1},
		'{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1, 1'b1},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b0}
	};

	logic [vid_pkg::SIZE_W-1:0] size_plan [7][3] = '{
		'{3'd0, 3'd0, 3'd0}, '{3'd4, 3'd4, 3'd4}, '{3'd7, 3'd7, 3'd7},
		'{3'd5, 3'd6, 3'd7}, '{3'd1, 3'd2, 3'd3}, '{3'd0, 3'd4, 3'd0},
		'{3'd4, 3'd0, 3'd1}
	};

	function automatic void weld_corner(vid_pkg::corner_t c);
		vid_pkg::key_t              k;
		int                         found;
		logic [vid_pkg::SIZE_W-1:0] words;
		vid_pkg::result_t           beat;
		if (c.mode) begin
			vertex_total = 0;
			n_clear++;
			return;
		end
		n_corner++;
		k[0] = c.position_index;
		k[1] = c.normal_index;
		k[2] = c.texcoord_index;
		found = -1;
		for (int e = 0; e < vertex_total; e++)
			if (found < 0 && welded[e] == k)
				found = e;
		if (found >= 0) begin
			beat = '{vid_pkg::ATTR_VERTEX, vid_pkg::VALUE_W'(found), 1'b0, 1'b0, 1'b1};
			vertex_results_due.push_back(beat);
			n_hit++;
		end else if (vertex_total >= vid_pkg::TABLE_DEPTH) begin
			beat = '{vid_pkg::ATTR_VERTEX, '0, 1'b1, 1'b1, 1'b1};
			vertex_results_due.push_back(beat);
			n_full++;
		end else begin
			for (int a = 0; a < 3; a++) begin
				words = (size_reg[a] > 3'd4) ? 3'd4 : size_reg[a];
				for (int w = 0; w < int'(words); w++) begin
					beat = '{vid_pkg::kind_t'(2'(a)),
						vid_pkg::VALUE_W'(int'(k[a]) * int'(words) + w),
						1'b1, 1'b0, 1'b0};
					vertex_results_due.push_back(beat);
				end
			end
			welded[vertex_total] = k;
			beat = '{vid_pkg::ATTR_VERTEX, vid_pkg::VALUE_W'(vertex_total), 1'b1, 1'b0, 1'b1};
			vertex_results_due.push_back(beat);
			vertex_total++;
			n_new++;
		end
	endfunction

	task automatic send_beat(vid_pkg::corner_t c, bit typed, vid_pkg::result_t tail);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			corner_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		corner = c;
		corner_valid = 1'b1;
		do @(posedge clk); while (corner_stall);
		weld_corner(c);
		if (typed)
			vertex_results_due[$] = tail;
		@(negedge clk);
	endtask

	// clear beats give no result but may still be in the row
	task automatic wait_idle();
		corner_valid = 1'b0;
		while (vertex_results_due.size() != 0)
			@(posedge clk);
		repeat (vid_pkg::TABLE_DEPTH + 16) @(negedge clk);
	endtask

	task automatic write_reg(vid_pkg::reg_index_t r, logic [vid_pkg::SIZE_W-1:0] v);
		wr_en = 1'b1;
		wr_index = r;
		wr_data = v;
		@(negedge clk);
		size_reg[r] = v;
		wr_en = 1'b0;
	endtask

	task automatic set_sizes(logic [vid_pkg::SIZE_W-1:0] p, logic [vid_pkg::SIZE_W-1:0] n,
		logic [vid_pkg::SIZE_W-1:0] t);
		wait_idle();
		write_reg(vid_pkg::REG_POSITION_SIZE, p);
		write_reg(vid_pkg::REG_NORMAL_SIZE, n);
		write_reg(vid_pkg::REG_TEXCOORD_SIZE, t);
		n_settings++;
	endtask

	function automatic logic [15:0] draw_index();
		int s;
		s = $urandom_range(0, 9);
		if (s < 6)
			return 16'($urandom_range(0, 3));
		else if (s < 7)
			return 16'hFFFF;
		else if (s < 8)
			return 16'hFFFF - 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	function automatic vid_pkg::corner_t draw_corner();
		vid_pkg::corner_t c;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '{1'b1, 16'($urandom), 16'($urandom), 16'($urandom)};
		if (r < 40 && recent.size() > 0)
			return recent[$urandom_range(0, recent.size() - 1)];
		c = '{1'b0, draw_index(), draw_index(), draw_index()};
		recent.push_back(c);
		if (recent.size() > 32)
			void'(recent.pop_front());
		return c;
	endfunction

	// result side: stall for a drawn count once a beat is offered
	initial begin
		int gap;
		forever begin
			gap = calm ? 0 : $urandom_range(0, 11);
			result_stall = (gap > 0);
			do @(posedge clk); while (!result_valid);
			if (gap > 0) begin
				repeat (gap) @(negedge clk);
				result_stall = 1'b0;
				do @(posedge clk); while (!result_valid);
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_beats++;
			if (vertex_results_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with nothing due (kind %0d value %0d)",
					$time, result.kind, result.value);
			end else begin
				want = vertex_results_due.pop_front();
				if (result.kind !== want.kind) begin
					mismatch_count++;
					$display("%0t: kind expected %0d got %0d", $time, want.kind, result.kind);
				end
				if (result.value !== want.value) begin
					mismatch_count++;
					$display("%0t: value expected %0d got %0d", $time, want.value,
						result.value);
				end
				if (result.is_new !== want.is_new) begin
					mismatch_count++;
					$display("%0t: is_new expected %0b got %0b", $time, want.is_new,
						result.is_new);
				end
				if (result.table_full !== want.table_full) begin
					mismatch_count++;
					$display("%0t: table_full expected %0b got %0b", $time, want.table_full,
						result.table_full);
				end
				if (result.last !== want.last) begin
					mismatch_count++;
					$display("%0t: last expected %0b got %0b", $time, want.last, result.last);
				end
			end
		end
	end

	initial begin
		#6000000;
		$display("timeout with %0d results still due", vertex_results_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		vid_pkg::corner_t c;
		vid_pkg::result_t tail;
		arst_n = 1'b0;
		corner_valid = 1'b0;
		corner = '0;
		wr_en = 1'b0;
		wr_index = vid_pkg::REG_POSITION_SIZE;
		wr_data = '0;
		calm = 1'b0;
		mismatch_count = 0;
		vertex_total = 0;
		size_reg = '{vid_pkg::POSITION_SIZE_RST, vid_pkg::NORMAL_SIZE_RST,
			vid_pkg::TEXCOORD_SIZE_RST};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 17; i++) begin
			c = '{probes[i].mode, probes[i].p, probes[i].n, probes[i].t};
			tail = '{vid_pkg::ATTR_VERTEX, vid_pkg::VALUE_W'(probes[i].num), probes[i].fresh,
				1'b0, 1'b1};
			send_beat(c, probes[i].typed, tail);
		end

		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 3 == 2);
			if (ph < 7)
				set_sizes(size_plan[ph][0], size_plan[ph][1], size_plan[ph][2]);
			else
				set_sizes(3'($urandom), 3'($urandom), 3'($urandom));
			if ($urandom_range(0, 1))
				send_beat('{1'b1, 16'($urandom), 16'($urandom), 16'($urandom)}, 1'b0, '0);
			repeat (40) send_beat(draw_corner(), 1'b0, '0);
		end

		// fill the table, overflow it, hit its last and first entries, then clear it and send a new corner
		calm = 1'b0;
		set_sizes(3'd0, 3'd0, 3'd0);
		send_beat('{1'b1, 16'h0, 16'h0, 16'h0}, 1'b0, '0);
		for (int i = 0; i < vid_pkg::TABLE_DEPTH; i++)
			send_beat('{1'b0, 16'(i), 16'($urandom), 16'($urandom)}, 1'b0, '0);
		for (int j = 0; j < 3; j++) begin
			tail = '{vid_pkg::ATTR_VERTEX, '0, 1'b1, 1'b1, 1'b1};
			send_beat('{1'b0, 16'hF000 + 16'(j), 16'hFFFF, 16'h0000}, 1'b1, tail);
		end
		send_beat('{1'b0, welded[vid_pkg::TABLE_DEPTH-1][0], welded[vid_pkg::TABLE_DEPTH-1][1],
			welded[vid_pkg::TABLE_DEPTH-1][2]}, 1'b0, '0);
		send_beat('{1'b0, welded[0][0], welded[0][1], welded[0][2]}, 1'b0, '0);
		send_beat('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0);
		send_beat('{1'b0, 16'hF000, 16'hFFFF, 16'h0000}, 1'b0, '0);

		wait_idle();
		$display("corners %0d: %0d new, %0d repeated, %0d refused on a full table; %0d clears",
			n_corner, n_new, n_hit, n_full, n_clear);
		$display("%0d result beats checked over %0d size settings", n_beats, n_settings);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
